>>> src/fpad_pkg.sv
// fpad_pkg: request and result types, cordic arctangent table and helpers
// for the fresnel phase azimuth derivative core
// no dependencies
`default_nettype none

package fpad_pkg;

	typedef struct packed {
		logic [31:0] wavenumber;
		logic [31:0] ring_radius;
		logic [31:0] reference_radius;
		logic [31:0] ring_azimuth;
		logic [31:0] reference_azimuth;
		logic [31:0] opening_angle;
		logic [31:0] observer_distance;
	} in_t;

	typedef struct packed {
		logic signed [63:0] phase_slope;
		logic               error_flag;
	} out_t;

	localparam int ATAN_ENTRIES = 32;
	localparam int NORM_BITS    = 24;
	localparam int ROOT_STEPS   = 32;
	localparam int DIV_BITS     = 56;
	localparam int LANES        = 4;

	localparam int LANE_B   = 0;
	localparam int LANE_PHI = 1;
	localparam int LANE_PH0 = 2;
	localparam int LANE_DPH = 3;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [29:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81,
		30'd41,        30'd20,        30'd10,        30'd5,
		30'd3,         30'd1,         30'd1,         30'd0
	};

	typedef logic [NORM_BITS-1:0] norm_t;

	typedef struct packed {
		logic [31:0]            k;
		logic [31:0]            r;
		logic [31:0]            r0;
		logic [31:0]            d;
		logic [31:0]            mx;
		logic [5:0]             bl;
		norm_t                  rn;
		norm_t                  r0n;
		norm_t                  dn;
		logic [LANES-1:0][1:0]  quad;
		logic                   d_zero;
	} cside_t;

	typedef struct packed {
		logic signed [59:0] m;
		logic signed [29:0] cs4;
		logic [63:0]        kr;
		logic               d_zero;
	} rside_t;

	typedef struct packed {
		logic               neg;
		logic signed [29:0] cs4;
		logic [63:0]        kr;
		logic               err;
		logic [31:0]        p;
	} dside_t;

	function automatic logic [29:0] atan_step(input int i);
		logic [29:0] s;
		s = '0;
		if (i < ATAN_ENTRIES) begin
			s = ATAN_TURNS[i % ATAN_ENTRIES];
		end
		return s;
	endfunction

	function automatic logic [5:0] bit_len(input logic [31:0] v);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				n = 6'(i + 1);
			end
		end
		return n;
	endfunction

	function automatic norm_t norm_val(input logic [31:0] v, input logic [5:0] bl);
		logic [31:0] t;
		if (bl > 6'(NORM_BITS)) begin
			t = v >> (bl - 6'(NORM_BITS));
		end else begin
			t = v << (6'(NORM_BITS) - bl);
		end
		return t[NORM_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

>>> src/fresnel_phase_azimuth_derivative_core.sv
// fresnel_phase_azimuth_derivative_core: pipelined fresnel phase slope d psi / d phi
// uses fpad_pkg for request and result types, cordic table and helpers
`default_nettype none

// One request per clock while the pipeline is not stalled. A request passes
// through four cordic lanes with one micro-rotation per stage, a 32-stage
// square root, a 56-stage restoring divider, then the product and
// saturation stages. The whole pipeline stalls only when the result
// register is held and the last stage is occupied, so requests keep
// entering while a result waits. Result is signed Q16.16, saturated;
// error_flag marks zero distance or zero psi0 with a zero slope.
module fresnel_phase_azimuth_derivative_core #(
	parameter int CORDIC_STAGES = 32
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  fpad_pkg::in_t    in_data,
	output logic             out_valid,
	input  wire              out_ready,
	output fpad_pkg::out_t   out_data
);

	localparam int N  = CORDIC_STAGES;
	localparam int RS = fpad_pkg::ROOT_STEPS;
	localparam int DB = fpad_pkg::DIV_BITS;
	localparam int NL = fpad_pkg::LANES;

	logic en;
	logic out_free;
	logic out_valid_q;
	fpad_pkg::out_t out_q;

	// cordic pipeline, index 0 is the input stage
	logic signed [33:0] cx_sc [0:N][0:NL-1];
	logic signed [33:0] cy_sc [0:N][0:NL-1];
	logic signed [33:0] cz_sc [0:N][0:NL-1];
	fpad_pkg::cside_t   cs_sc [0:N];
	logic               vc_sc [0:N];

	logic [31:0]        ang_w [0:NL-1];
	logic [1:0]         quad_w [0:NL-1];
	logic signed [33:0] z0_w [0:NL-1];
	logic [31:0]        mx_w;

	logic signed [33:0] co_s2 [0:NL-1];
	logic signed [33:0] si_s2 [0:NL-1];
	fpad_pkg::cside_t   side_s2;
	logic               v_s2;

	logic signed [58:0] rcp_s3, r0c_s3, rsp_s3, r0s_s3, dcb_s3, dsb_s3;
	logic signed [67:0] csp_s3;
	logic signed [33:0] sd_s3;
	fpad_pkg::cside_t   side_s3;
	logic               v_s3;

	logic signed [33:0] ux_w, uy_w;
	logic signed [34:0] ax_w;
	logic signed [31:0] ax_s4, uy_s4, ds_s4;
	logic signed [33:0] cs_s4, sd_s4;
	fpad_pkg::cside_t   side_s4;
	logic               v_s4;

	logic [63:0]        sqa_s5, squ_s5, sqd_s5, kr_s5;
	logic signed [58:0] mr_s5, md_s5;
	logic signed [29:0] cs4_s5;
	logic               dz_s5;
	logic               v_s5;

	// square root pipeline, index 0 holds the sums
	logic [63:0]        rq_sr [0:RS];
	logic [63:0]        rt_sr [0:RS];
	fpad_pkg::rside_t   rs_sr [0:RS];
	logic               vr_sr [0:RS];

	// divider pipeline, index 0 holds divisor and dividend
	logic [31:0]        dr_sd [0:DB];
	logic [DB-1:0]      dq_sd [0:DB];
	logic [DB-1:0]      dv_sd [0:DB];
	fpad_pkg::dside_t   ds_sd [0:DB];
	logic               vd_sd [0:DB];

	logic signed [59:0] mneg_w;
	fpad_pkg::dside_t   dsn_w;
	logic [DB-1:0]      magm_w;

	logic signed [57:0] t_w, t_s8, br_s9, brneg_w;
	fpad_pkg::dside_t   ds_s8, ds_s9;
	logic               v_s8, v_s9;

	logic [56:0]        mb_s10;
	logic               bn_s10, err_s10, v_s10;
	logic [63:0]        kr_s10;

	logic [60:0]        pll_s11, phl_s11;
	logic [59:0]        plh_s11, phh_s11;
	logic               bn_s11, err_s11, v_s11;

	logic [89:0]        a_s12, b_s12;
	logic               bn_s12, err_s12, v_s12;

	logic [121:0]       full_s13;
	logic               bn_s13, err_s13, v_s13;

	logic [63:0]        res_w, negres_w;
	logic               pos_ovf_w, neg_ovf_w;
	fpad_pkg::out_t     out_w;

	assign out_free  = !out_valid_q || out_ready;
	assign en        = out_free || !v_s13;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// input stage: quadrant reduction and range of the distances
	assign ang_w[fpad_pkg::LANE_B]   = in_data.opening_angle;
	assign ang_w[fpad_pkg::LANE_PHI] = in_data.ring_azimuth;
	assign ang_w[fpad_pkg::LANE_PH0] = in_data.reference_azimuth;
	assign ang_w[fpad_pkg::LANE_DPH] = in_data.ring_azimuth - in_data.reference_azimuth;

	always_comb begin
		logic [31:0] sum;
		logic [31:0] res;
		for (int l = 0; l < NL; l++) begin
			sum = ang_w[l] + 32'h2000_0000;
			quad_w[l] = sum[31:30];
			res = ang_w[l] - {sum[31:30], 30'b0};
			z0_w[l] = $signed({{2{res[31]}}, res});
		end
	end

	always_comb begin
		mx_w = in_data.ring_radius;
		if (in_data.reference_radius > mx_w) begin
			mx_w = in_data.reference_radius;
		end
		if (in_data.observer_distance > mx_w) begin
			mx_w = in_data.observer_distance;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NL; l++) begin
				cx_sc[0][l] <= fpad_pkg::CORDIC_GAIN;
				cy_sc[0][l] <= '0;
				cz_sc[0][l] <= z0_w[l];
				cs_sc[0].quad[l] <= quad_w[l];
			end
			cs_sc[0].k      <= in_data.wavenumber;
			cs_sc[0].r      <= in_data.ring_radius;
			cs_sc[0].r0     <= in_data.reference_radius;
			cs_sc[0].d      <= in_data.observer_distance;
			cs_sc[0].mx     <= mx_w;
			cs_sc[0].bl     <= '0;
			cs_sc[0].rn     <= '0;
			cs_sc[0].r0n    <= '0;
			cs_sc[0].dn     <= '0;
			cs_sc[0].d_zero <= (in_data.observer_distance == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_sc[0] <= 1'b0;
		end else if (en) begin
			vc_sc[0] <= in_valid;
		end
	end

	// cordic micro-rotations, normalisation rides along in the first two stages
	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cordic
			localparam logic signed [33:0] STEP = $signed({4'b0, fpad_pkg::atan_step(g)});
			fpad_pkg::cside_t side_n;

			always_comb begin
				side_n = cs_sc[g];
				if (g == 0) begin
					side_n.bl = fpad_pkg::bit_len(cs_sc[g].mx);
				end
				if (g == 1) begin
					side_n.rn  = fpad_pkg::norm_val(cs_sc[g].r, cs_sc[g].bl);
					side_n.r0n = fpad_pkg::norm_val(cs_sc[g].r0, cs_sc[g].bl);
					side_n.dn  = fpad_pkg::norm_val(cs_sc[g].d, cs_sc[g].bl);
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					for (int l = 0; l < NL; l++) begin
						if (!cz_sc[g][l][33]) begin
							cx_sc[g+1][l] <= cx_sc[g][l] - (cy_sc[g][l] >>> g);
							cy_sc[g+1][l] <= cy_sc[g][l] + (cx_sc[g][l] >>> g);
							cz_sc[g+1][l] <= cz_sc[g][l] - STEP;
						end else begin
							cx_sc[g+1][l] <= cx_sc[g][l] + (cy_sc[g][l] >>> g);
							cy_sc[g+1][l] <= cy_sc[g][l] - (cx_sc[g][l] >>> g);
							cz_sc[g+1][l] <= cz_sc[g][l] + STEP;
						end
					end
					cs_sc[g+1] <= side_n;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vc_sc[g+1] <= 1'b0;
				end else if (en) begin
					vc_sc[g+1] <= vc_sc[g];
				end
			end
		end
	endgenerate

	// quadrant fold back
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NL; l++) begin
				case (cs_sc[N].quad[l])
					2'd0: begin
						co_s2[l] <= cx_sc[N][l];
						si_s2[l] <= cy_sc[N][l];
					end
					2'd1: begin
						co_s2[l] <= -cy_sc[N][l];
						si_s2[l] <= cx_sc[N][l];
					end
					2'd2: begin
						co_s2[l] <= -cx_sc[N][l];
						si_s2[l] <= -cy_sc[N][l];
					end
					default: begin
						co_s2[l] <= cy_sc[N][l];
						si_s2[l] <= -cx_sc[N][l];
					end
				endcase
			end
			side_s2 <= cs_sc[N];
		end
	end

	// coordinate products
	always_ff @(posedge clk) begin
		if (en) begin
			rcp_s3 <= $signed({1'b0, side_s2.rn}) * co_s2[fpad_pkg::LANE_PHI];
			r0c_s3 <= $signed({1'b0, side_s2.r0n}) * co_s2[fpad_pkg::LANE_PH0];
			rsp_s3 <= $signed({1'b0, side_s2.rn}) * si_s2[fpad_pkg::LANE_PHI];
			r0s_s3 <= $signed({1'b0, side_s2.r0n}) * si_s2[fpad_pkg::LANE_PH0];
			dcb_s3 <= $signed({1'b0, side_s2.dn}) * co_s2[fpad_pkg::LANE_B];
			dsb_s3 <= $signed({1'b0, side_s2.dn}) * si_s2[fpad_pkg::LANE_B];
			csp_s3 <= co_s2[fpad_pkg::LANE_B] * si_s2[fpad_pkg::LANE_PHI];
			sd_s3  <= si_s2[fpad_pkg::LANE_DPH];
			side_s3 <= side_s2;
		end
	end

	// floor shifts to q.4 and q1.30
	assign ux_w = $signed(rcp_s3[58:26]) - $signed(r0c_s3[58:26]);
	assign uy_w = $signed(rsp_s3[58:26]) - $signed(r0s_s3[58:26]);
	assign ax_w = ux_w - $signed(dcb_s3[58:26]);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s4   <= ax_w[31:0];
			uy_s4   <= uy_w[31:0];
			ds_s4   <= dsb_s3[57:26];
			cs_s4   <= csp_s3[63:30];
			sd_s4   <= sd_s3;
			side_s4 <= side_s3;
		end
	end

	// squares and numerator products
	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s5 <= ax_s4 * ax_s4;
			squ_s5 <= uy_s4 * uy_s4;
			sqd_s5 <= ds_s4 * ds_s4;
			mr_s5  <= $signed({1'b0, side_s4.r0n}) * sd_s4;
			md_s5  <= $signed({1'b0, side_s4.dn}) * cs_s4;
			kr_s5  <= side_s4.k * side_s4.r;
			cs4_s5 <= cs_s4[33:4];
			dz_s5  <= side_s4.d_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rq_sr[0]        <= sqa_s5 + squ_s5 + sqd_s5;
			rt_sr[0]        <= '0;
			rs_sr[0].m      <= mr_s5 + md_s5;
			rs_sr[0].cs4    <= cs4_s5;
			rs_sr[0].kr     <= kr_s5;
			rs_sr[0].d_zero <= dz_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			vr_sr[0] <= 1'b0;
		end else if (en) begin
			v_s2     <= vc_sc[N];
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			vr_sr[0] <= v_s5;
		end
	end

	// square root, one result bit per stage
	generate
		for (g = 0; g < RS; g++) begin : g_root
			localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * g);
			logic [63:0] trial;

			assign trial = rt_sr[g] + RBIT;

			always_ff @(posedge clk) begin
				if (en) begin
					if (rq_sr[g] >= trial) begin
						rq_sr[g+1] <= rq_sr[g] - trial;
						rt_sr[g+1] <= (rt_sr[g] >> 1) + RBIT;
					end else begin
						rq_sr[g+1] <= rq_sr[g];
						rt_sr[g+1] <= rt_sr[g] >> 1;
					end
					rs_sr[g+1] <= rs_sr[g];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vr_sr[g+1] <= 1'b0;
				end else if (en) begin
					vr_sr[g+1] <= vr_sr[g];
				end
			end
		end
	endgenerate

	// divider set-up: magnitude of the numerator, error check
	assign mneg_w = -rs_sr[RS].m;
	assign magm_w = rs_sr[RS].m[59] ? mneg_w[DB-1:0] : rs_sr[RS].m[DB-1:0];

	always_comb begin
		dsn_w.neg = rs_sr[RS].m[59];
		dsn_w.cs4 = rs_sr[RS].cs4;
		dsn_w.kr  = rs_sr[RS].kr;
		dsn_w.err = rs_sr[RS].d_zero || (rt_sr[RS] == '0);
		dsn_w.p   = rt_sr[RS][31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr_sd[0] <= '0;
			dq_sd[0] <= '0;
			dv_sd[0] <= magm_w;
			ds_sd[0] <= dsn_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_sd[0] <= 1'b0;
		end else if (en) begin
			vd_sd[0] <= vr_sr[RS];
		end
	end

	// restoring division, one quotient bit per stage
	generate
		for (g = 0; g < DB; g++) begin : g_div
			logic [32:0] part;
			logic [32:0] diff;
			logic        ge;

			assign part = {dr_sd[g], dv_sd[g][DB-1]};
			assign diff = part - {1'b0, ds_sd[g].p};
			assign ge   = (part >= {1'b0, ds_sd[g].p});

			always_ff @(posedge clk) begin
				if (en) begin
					dr_sd[g+1] <= ge ? diff[31:0] : part[31:0];
					dq_sd[g+1] <= {dq_sd[g][DB-2:0], ge};
					dv_sd[g+1] <= {dv_sd[g][DB-2:0], 1'b0};
					ds_sd[g+1] <= ds_sd[g];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vd_sd[g+1] <= 1'b0;
				end else if (en) begin
					vd_sd[g+1] <= vd_sd[g];
				end
			end
		end
	endgenerate

	// signed quotient, bracket, magnitude
	assign t_w     = ds_sd[DB].neg ? -$signed({2'b0, dq_sd[DB]}) : $signed({2'b0, dq_sd[DB]});
	assign brneg_w = -br_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s8    <= t_w;
			ds_s8   <= ds_sd[DB];
			br_s9   <= t_s8 - ds_s8.cs4;
			ds_s9   <= ds_s8;
			bn_s10  <= br_s9[57];
			mb_s10  <= br_s9[57] ? brneg_w[56:0] : br_s9[56:0];
			kr_s10  <= ds_s9.kr;
			err_s10 <= ds_s9.err;
		end
	end

	// k*r times bracket magnitude in partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pll_s11  <= kr_s10[31:0] * mb_s10[28:0];
			plh_s11  <= kr_s10[31:0] * mb_s10[56:29];
			phl_s11  <= kr_s10[63:32] * mb_s10[28:0];
			phh_s11  <= kr_s10[63:32] * mb_s10[56:29];
			bn_s11   <= bn_s10;
			err_s11  <= err_s10;
			a_s12    <= pll_s11 + {plh_s11, 29'b0};
			b_s12    <= phl_s11 + {phh_s11, 29'b0};
			bn_s12   <= bn_s11;
			err_s12  <= err_s11;
			full_s13 <= a_s12 + {b_s12, 32'b0};
			bn_s13   <= bn_s12;
			err_s13  <= err_s12;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s8  <= vd_sd[DB];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// scale to q16.16 and saturate
	assign res_w     = full_s13[89:26];
	assign negres_w  = -res_w;
	assign pos_ovf_w = |full_s13[121:89];
	assign neg_ovf_w = (|full_s13[121:90]) || (full_s13[89] && (|full_s13[88:26]));

	always_comb begin
		out_w.error_flag = err_s13;
		if (err_s13) begin
			out_w.phase_slope = '0;
		end else if (bn_s13) begin
			out_w.phase_slope = neg_ovf_w ? {1'b1, 63'b0} : $signed(negres_w);
		end else begin
			out_w.phase_slope = pos_ovf_w ? {1'b0, {63{1'b1}}} : $signed(res_w);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= out_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s13;
		end
	end

endmodule

`default_nettype wire
